>>> hw/rtl/fdr_pkg.sv
// Package for the fraction divide/reduce block: microcode word, status flags
// and the control-store program. Used by fraction_divide_reduce and fdr_datapath.
package fdr_pkg;

  localparam int PC_W = 5;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_MUL_NUM,
    OP_MUL_DEN,
    OP_GCD_LOAD,
    OP_SHIFT_BOTH,
    OP_HALVE_X,
    OP_HALVE_Y,
    OP_SUB,
    OP_UNSHIFT,
    OP_DIV_LOAD_NUM,
    OP_DIV_LOAD_DEN,
    OP_DIV_STEP,
    OP_STORE_NUM,
    OP_STORE_DEN,
    OP_EMIT_RESULT,
    OP_EMIT_DBZ,
    OP_EMIT_ZERO
  } op_t;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_ANY_ZERO,
    COND_NUM_ZERO,
    COND_BOTH_EVEN,
    COND_X_EVEN,
    COND_Y_EVEN,
    COND_X_NE_Y,
    COND_K_NZ,
    COND_CNT_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
    logic  done;
  } uword_t;

  typedef struct packed {
    logic any_zero;
    logic num_zero;
    logic both_even;
    logic x_even;
    logic y_even;
    logic x_ne_y;
    logic k_nz;
    logic cnt_more;
  } stat_t;

  // Step addresses used as jump targets
  localparam pc_t PC_SHIFT_BOTH = pc_t'(3);
  localparam pc_t PC_HALVE_X    = pc_t'(4);
  localparam pc_t PC_HALVE_Y    = pc_t'(5);
  localparam pc_t PC_UNSHIFT    = pc_t'(7);
  localparam pc_t PC_DIV_NUM    = pc_t'(9);
  localparam pc_t PC_DIV_DEN    = pc_t'(12);
  localparam pc_t PC_EMIT_DBZ   = pc_t'(15);
  localparam pc_t PC_EMIT_ZERO  = pc_t'(16);

  localparam uword_t UWORD_NOP = '{op: OP_NOP, cond: COND_NEVER, target: '0, done: 1'b0};

  // Control store: binary GCD, then two restoring divisions by the GCD
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = UWORD_NOP;
    case (pc)
      pc_t'(0):  w = '{OP_MUL_NUM,      COND_ANY_ZERO,  PC_EMIT_DBZ,   1'b0};
      pc_t'(1):  w = '{OP_MUL_DEN,      COND_NEVER,     '0,            1'b0};
      pc_t'(2):  w = '{OP_GCD_LOAD,     COND_NUM_ZERO,  PC_EMIT_ZERO,  1'b0};
      pc_t'(3):  w = '{OP_SHIFT_BOTH,   COND_BOTH_EVEN, PC_SHIFT_BOTH, 1'b0};
      pc_t'(4):  w = '{OP_HALVE_X,      COND_X_EVEN,    PC_HALVE_X,    1'b0};
      pc_t'(5):  w = '{OP_HALVE_Y,      COND_Y_EVEN,    PC_HALVE_Y,    1'b0};
      pc_t'(6):  w = '{OP_SUB,          COND_X_NE_Y,    PC_HALVE_Y,    1'b0};
      pc_t'(7):  w = '{OP_UNSHIFT,      COND_K_NZ,      PC_UNSHIFT,    1'b0};
      pc_t'(8):  w = '{OP_DIV_LOAD_NUM, COND_NEVER,     '0,            1'b0};
      pc_t'(9):  w = '{OP_DIV_STEP,     COND_CNT_MORE,  PC_DIV_NUM,    1'b0};
      pc_t'(10): w = '{OP_STORE_NUM,    COND_NEVER,     '0,            1'b0};
      pc_t'(11): w = '{OP_DIV_LOAD_DEN, COND_NEVER,     '0,            1'b0};
      pc_t'(12): w = '{OP_DIV_STEP,     COND_CNT_MORE,  PC_DIV_DEN,    1'b0};
      pc_t'(13): w = '{OP_STORE_DEN,    COND_NEVER,     '0,            1'b0};
      pc_t'(14): w = '{OP_EMIT_RESULT,  COND_NEVER,     '0,            1'b1};
      pc_t'(15): w = '{OP_EMIT_DBZ,     COND_NEVER,     '0,            1'b1};
      pc_t'(16): w = '{OP_EMIT_ZERO,    COND_NEVER,     '0,            1'b1};
      // unused addresses: end the transaction without a result
      default:   w = '{OP_NOP,          COND_NEVER,     '0,            1'b1};
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/fdr_datapath.sv
// Datapath of the fraction divide/reduce block: operand registers, shared
// multiplier, binary GCD registers, restoring divider and result registers.
// Depends on fdr_pkg for the microcode word and status types.
module fdr_datapath #(
  parameter int W = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic signed [W-1:0]  left_num,
  input  logic signed [W-1:0]  left_den,
  input  logic signed [W-1:0]  right_num,
  input  logic signed [W-1:0]  right_den,
  input  fdr_pkg::uword_t      ctrl,
  output fdr_pkg::stat_t       stat,
  output logic                 res_valid,
  output logic signed [31:0]   res_num,
  output logic [30:0]          res_den,
  output logic                 res_whole,
  output logic                 res_dbz
);

  localparam int PW = 2 * W;
  localparam int CW = $clog2(PW);
  localparam int EW = (PW > 32) ? PW : 32;

  logic [W-1:0]  a_r, b_r, c_r, d_r;
  logic          neg_r;
  logic [PW-1:0] num_r, den_r, x_r, y_r, rem_r;
  logic [CW-1:0] k_r, cnt_r;
  logic          valid_r;
  logic signed [31:0] qnum_r;
  logic [30:0]   qden_r;
  logic          whole_r, dbz_r;

  logic [W-1:0]  mag_a, mag_b, mag_c, mag_d;
  logic [W-1:0]  mul_a, mul_b;
  logic [PW-1:0] prod;
  logic [PW:0]   rem_sh, div_diff;
  logic          div_ge;
  logic          x_lt_y;
  logic [EW-1:0] num_ext, num_signed;
  logic [EW-1:0] den_ext;

  function automatic logic [W-1:0] mag(input logic [W-1:0] raw);
    return raw[W-1] ? (~raw + W'(1)) : raw;
  endfunction

  assign mag_a = mag(left_num);
  assign mag_b = mag(left_den);
  assign mag_c = mag(right_num);
  assign mag_d = mag(right_den);

  // one multiplier, shared by the two cross products
  assign mul_a = (ctrl.op == fdr_pkg::OP_MUL_DEN) ? b_r : a_r;
  assign mul_b = (ctrl.op == fdr_pkg::OP_MUL_DEN) ? c_r : d_r;
  assign prod  = PW'(mul_a) * PW'(mul_b);

  // restoring divide step: y_r holds the dividend/quotient, x_r the divisor
  assign rem_sh   = {rem_r, y_r[PW-1]};
  assign div_diff = rem_sh - {1'b0, x_r};
  assign div_ge   = !div_diff[PW];

  assign x_lt_y = x_r < y_r;

  assign num_ext    = EW'(num_r);
  assign num_signed = neg_r ? (~num_ext + EW'(1)) : num_ext;
  assign den_ext    = EW'(den_r);

  always_comb begin
    stat.any_zero  = (b_r == '0) || (c_r == '0) || (d_r == '0);
    stat.num_zero  = (num_r == '0);
    stat.both_even = !x_r[0] && !y_r[0];
    stat.x_even    = !x_r[0];
    stat.y_even    = !y_r[0];
    stat.x_ne_y    = (x_r != y_r);
    stat.k_nz      = (k_r != '0);
    stat.cnt_more  = (cnt_r != CW'(PW - 1));
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_r   <= mag_a;
      b_r   <= mag_b;
      c_r   <= mag_c;
      d_r   <= mag_d;
      neg_r <= left_num[W-1] ^ left_den[W-1] ^ right_num[W-1] ^ right_den[W-1];
    end
    case (ctrl.op)
      fdr_pkg::OP_MUL_NUM: num_r <= prod;
      fdr_pkg::OP_MUL_DEN: den_r <= prod;
      fdr_pkg::OP_GCD_LOAD: begin
        x_r <= num_r;
        y_r <= den_r;
        k_r <= '0;
      end
      fdr_pkg::OP_SHIFT_BOTH: begin
        if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + CW'(1);
        end
      end
      fdr_pkg::OP_HALVE_X: begin
        if (!x_r[0]) x_r <= x_r >> 1;
      end
      fdr_pkg::OP_HALVE_Y: begin
        if (!y_r[0]) y_r <= y_r >> 1;
      end
      fdr_pkg::OP_SUB: begin
        // keep the smaller value in x, the difference in y
        if (x_lt_y) begin
          y_r <= y_r - x_r;
        end else begin
          x_r <= y_r;
          y_r <= x_r - y_r;
        end
      end
      fdr_pkg::OP_UNSHIFT: begin
        if (k_r != '0) begin
          x_r <= x_r << 1;
          k_r <= k_r - CW'(1);
        end
      end
      fdr_pkg::OP_DIV_LOAD_NUM: begin
        y_r   <= num_r;
        rem_r <= '0;
        cnt_r <= '0;
      end
      fdr_pkg::OP_DIV_LOAD_DEN: begin
        y_r   <= den_r;
        rem_r <= '0;
        cnt_r <= '0;
      end
      fdr_pkg::OP_DIV_STEP: begin
        rem_r <= div_ge ? div_diff[PW-1:0] : rem_sh[PW-1:0];
        y_r   <= {y_r[PW-2:0], div_ge};
        cnt_r <= cnt_r + CW'(1);
      end
      fdr_pkg::OP_STORE_NUM: num_r <= y_r;
      fdr_pkg::OP_STORE_DEN: den_r <= y_r;
      fdr_pkg::OP_EMIT_RESULT: begin
        qnum_r  <= num_signed[31:0];
        qden_r  <= den_ext[30:0];
        whole_r <= (den_r == PW'(1));
        dbz_r   <= 1'b0;
      end
      fdr_pkg::OP_EMIT_DBZ: begin
        qnum_r  <= '0;
        qden_r  <= '0;
        whole_r <= 1'b0;
        dbz_r   <= 1'b1;
      end
      fdr_pkg::OP_EMIT_ZERO: begin
        qnum_r  <= '0;
        qden_r  <= 31'd1;
        whole_r <= 1'b1;
        dbz_r   <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= (ctrl.op == fdr_pkg::OP_EMIT_RESULT) ||
                 (ctrl.op == fdr_pkg::OP_EMIT_DBZ) ||
                 (ctrl.op == fdr_pkg::OP_EMIT_ZERO);
    end
  end

  assign res_valid = valid_r;
  assign res_num   = qnum_r;
  assign res_den   = qden_r;
  assign res_whole = whole_r;
  assign res_dbz   = dbz_r;

endmodule

>>> hw/rtl/fraction_divide_reduce.sv
// Rational divide (a/b)/(c/d) reduced to lowest terms, microcoded sequencer.
// A zero divisor/denominator gives a division-by-zero result and a zero dividend a zero
// result; otherwise the sequence is a binary GCD followed by two restoring divisions
// by the GCD.
// One transaction at a time: start is not taken while busy. out_valid pulses one
// cycle, and start is taken in that cycle. rst_n is synchronous: it clears busy,
// the step counter and out_valid.
module fraction_divide_reduce #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [OPERAND_WIDTH-1:0]  in_left_num,
  input  logic signed [OPERAND_WIDTH-1:0]  in_left_den,
  input  logic signed [OPERAND_WIDTH-1:0]  in_right_num,
  input  logic signed [OPERAND_WIDTH-1:0]  in_right_den,
  output logic                             out_valid,
  output logic signed [31:0]               out_quot_num,
  output logic [30:0]                      out_quot_den,
  output logic                             out_whole_result,
  output logic                             out_div_by_zero
);

  logic            busy_r;
  fdr_pkg::pc_t    pc_r;
  fdr_pkg::uword_t word;
  fdr_pkg::uword_t ctrl;
  fdr_pkg::stat_t  stat;
  logic            accept;
  logic            take;

  assign accept = start && !busy_r;
  assign word   = fdr_pkg::ucode(pc_r);
  assign ctrl   = busy_r ? word : fdr_pkg::UWORD_NOP;

  always_comb begin
    case (word.cond)
      fdr_pkg::COND_NEVER:     take = 1'b0;
      fdr_pkg::COND_ALWAYS:    take = 1'b1;
      fdr_pkg::COND_ANY_ZERO:  take = stat.any_zero;
      fdr_pkg::COND_NUM_ZERO:  take = stat.num_zero;
      fdr_pkg::COND_BOTH_EVEN: take = stat.both_even;
      fdr_pkg::COND_X_EVEN:    take = stat.x_even;
      fdr_pkg::COND_Y_EVEN:    take = stat.y_even;
      fdr_pkg::COND_X_NE_Y:    take = stat.x_ne_y;
      fdr_pkg::COND_K_NZ:      take = stat.k_nz;
      fdr_pkg::COND_CNT_MORE:  take = stat.cnt_more;
      default:                 take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else if (accept) begin
      busy_r <= 1'b1;
      pc_r   <= '0;
    end else if (busy_r) begin
      // drop busy on the last step; always advance or jump the step counter
      if (word.done) busy_r <= 1'b0;
      pc_r <= take ? word.target : pc_r + fdr_pkg::pc_t'(1);
    end
  end

  assign busy = busy_r;

  fdr_datapath #(
    .W (OPERAND_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .left_num  (in_left_num),
    .left_den  (in_left_den),
    .right_num (in_right_num),
    .right_den (in_right_den),
    .ctrl      (ctrl),
    .stat      (stat),
    .res_valid (out_valid),
    .res_num   (out_quot_num),
    .res_den   (out_quot_den),
    .res_whole (out_whole_result),
    .res_dbz   (out_div_by_zero)
  );

endmodule

>>> sim/tb_fraction_divide_reduce.sv
// Self-checking bench for fraction_divide_reduce: directed and random operand sets,
// checked against an in-bench rational divide and reduce predictor.
// Depends on fraction_divide_reduce and, through it, fdr_datapath and fdr_pkg.
`timescale 1ns / 100ps

module tb_fraction_divide_reduce;

  localparam int OPW         = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_WAIT  = 400;
  localparam int RANDOM_SETS = 1200;

  typedef struct {
    logic signed [OPW-1:0] left_num;
    logic signed [OPW-1:0] left_den;
    logic signed [OPW-1:0] right_num;
    logic signed [OPW-1:0] right_den;
    bit                    drain;     // hold the sender until every result is back
  } operands_t;

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               whole;
    logic               dbz;
  } quot_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic signed [OPW-1:0] in_left_num = '0;
  logic signed [OPW-1:0] in_left_den = '0;
  logic signed [OPW-1:0] in_right_num = '0;
  logic signed [OPW-1:0] in_right_den = '0;
  logic                  out_valid;
  logic signed [31:0]    out_quot_num;
  logic [30:0]           out_quot_den;
  logic                  out_whole_result;
  logic                  out_div_by_zero;

  operands_t operand_queue[$];
  quot_t     quot_expected[$];
  int        accept_cnt = 0;
  int        issue_cnt = 0;
  int        gap_left = 0;
  int        calm_from = 0;
  int        fail_cnt = 0;
  int        cycle_cnt = 0;

  fraction_divide_reduce #(
    .OPERAND_WIDTH (OPW)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_left_num      (in_left_num),
    .in_left_den      (in_left_den),
    .in_right_num     (in_right_num),
    .in_right_den     (in_right_den),
    .out_valid        (out_valid),
    .out_quot_num     (out_quot_num),
    .out_quot_den     (out_quot_den),
    .out_whole_result (out_whole_result),
    .out_div_by_zero  (out_div_by_zero)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic longint unsigned magnitude(input logic signed [OPW-1:0] v);
    longint s;
    s = v;
    return (s < 0) ? longint'(-s) : longint'(s);
  endfunction

  // (a/b) / (c/d) = (a*d) / (b*c), reduced, sign carried on the numerator
  function automatic quot_t divide_reduce(input operands_t op);
    longint unsigned a, b, c, d, num, den, x, y, t;
    bit neg;
    quot_t q;
    q = '0;
    a = magnitude(op.left_num);
    b = magnitude(op.left_den);
    c = magnitude(op.right_num);
    d = magnitude(op.right_den);
    if (b == 0 || c == 0 || d == 0) begin
      q.dbz = 1'b1;
      return q;
    end
    num = a * d;
    den = b * c;
    if (num == 0) begin
      q.den   = 31'd1;
      q.whole = 1'b1;
      return q;
    end
    neg = (op.left_num[OPW-1] ^ op.right_den[OPW-1]) ^ (op.left_den[OPW-1] ^ op.right_num[OPW-1]);
    x = num;
    y = den;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    num = num / x;
    den = den / x;
    q.num   = 32'(neg ? (64'd0 - num) : num);
    q.den   = 31'(den);
    q.whole = (den == 1);
    return q;
  endfunction

  function automatic logic signed [OPW-1:0] pick_operand();
    logic signed [OPW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = OPW'($urandom);
      3, 4:    v = OPW'(int'($urandom_range(0, 40)) - 20);
      5: begin
        case ($urandom_range(0, 4))
          0: v = {1'b1, {(OPW-1){1'b0}}};
          1: v = {1'b0, {(OPW-1){1'b1}}};
          2: v = '1;
          3: v = OPW'(1);
          default: v = '0;
        endcase
      end
      6: begin
        // powers of two, either sign
        v = OPW'(1) << $urandom_range(0, OPW - 2);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        // products of small factors give common divisors to cancel
        v = OPW'($urandom_range(1, 181) * $urandom_range(1, 181));
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic operands_t make_set(input int ln, input int ld, input int rn, input int rd);
    operands_t s;
    s.left_num  = OPW'(ln);
    s.left_den  = OPW'(ld);
    s.right_num = OPW'(rn);
    s.right_den = OPW'(rd);
    s.drain     = 1'b0;
    return s;
  endfunction

  // append an operand set at the tail of the pending queue
  function automatic void queue_set(input operands_t s);
    operand_queue.insert(operand_queue.size(), s);
  endfunction

  // Driver: raise start with the next operand set, hold it until taken
  always @(negedge clk) begin
    operands_t nx;
    bit        quiet;
    if (rst_n && !(start && accept_cnt != issue_cnt)) begin
      quiet = (issue_cnt >= calm_from) || (((issue_cnt / 64) % 3) == 2);
      if (start && !quiet && $urandom_range(0, 2) == 0)
        gap_left = $urandom_range(1, 6);
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (operand_queue.size() != 0 && operand_queue[0].drain) begin
        if (quot_expected.size() == 0)
          void'(operand_queue.pop_front());
        start <= 1'b0;
      end else if (operand_queue.size() != 0) begin
        nx = operand_queue.pop_front();
        in_left_num  <= nx.left_num;
        in_left_den  <= nx.left_den;
        in_right_num <= nx.right_num;
        in_right_den <= nx.right_den;
        start        <= 1'b1;
        issue_cnt++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check the result first, then record a newly accepted transaction
  always @(posedge clk) begin
    quot_t     exp_q;
    operands_t taken;
    if (rst_n) begin
      if (out_valid) begin
        if (quot_expected.size() == 0) begin
          $error("unexpected result: num %0d den %0d", out_quot_num, out_quot_den);
          fail_cnt++;
        end else begin
          exp_q = quot_expected.pop_front();
          if (out_quot_num !== exp_q.num) begin
            $error("quot_num: expected %0d, got %0d", exp_q.num, out_quot_num);
            fail_cnt++;
          end
          if (out_quot_den !== exp_q.den) begin
            $error("quot_den: expected %0d, got %0d", exp_q.den, out_quot_den);
            fail_cnt++;
          end
          if (out_whole_result !== exp_q.whole) begin
            $error("whole_result: expected %0b, got %0b", exp_q.whole, out_whole_result);
            fail_cnt++;
          end
          if (out_div_by_zero !== exp_q.dbz) begin
            $error("div_by_zero: expected %0b, got %0b", exp_q.dbz, out_div_by_zero);
            fail_cnt++;
          end
        end
      end
      if (start && !busy) begin
        taken.left_num  = in_left_num;
        taken.left_den  = in_left_den;
        taken.right_num = in_right_num;
        taken.right_den = in_right_den;
        taken.drain     = 1'b0;
        quot_expected.insert(quot_expected.size(), divide_reduce(taken));
        accept_cnt <= accept_cnt + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    operands_t marker;
    marker = make_set(0, 0, 0, 0);
    marker.drain = 1'b1;

    // directed: extremes, zero cases, signs, reductions
    queue_set(make_set(1, 1, 1, 1));
    queue_set(make_set(32767, 1, 1, 32767));
    queue_set(make_set(-32768, 1, 1, -32768));
    queue_set(make_set(1, -32768, -32768, 1));
    queue_set(make_set(-32768, 1, 1, 32767));
    queue_set(make_set(32767, -32768, -32768, 32767));
    queue_set(make_set(0, 5, 3, 7));
    queue_set(make_set(0, -1, -3, 2));
    queue_set(make_set(3, 0, 1, 1));
    queue_set(make_set(3, 4, 0, 1));
    queue_set(make_set(3, 4, 5, 0));
    queue_set(make_set(0, 0, 0, 0));
    queue_set(make_set(0, 1, 0, 1));
    queue_set(make_set(6, 4, 9, 2));
    queue_set(make_set(3, -4, 5, 6));
    queue_set(make_set(-3, -4, -5, -6));
    queue_set(make_set(-3, 4, 5, -6));
    queue_set(make_set(10, 1, 5, 1));
    queue_set(make_set(7, 3, 7, 3));
    queue_set(make_set(1024, 1, 4096, 1));
    queue_set(make_set(-16384, 3, 2, -9));
    queue_set(make_set(-1, -1, -1, -1));
    queue_set(make_set(21845, -21846, 10922, 32767));
    queue_set(marker);

    for (int i = 0; i < RANDOM_SETS; i++) begin
      queue_set(make_set(pick_operand(), pick_operand(),
                         pick_operand(), pick_operand()));
      if (i == RANDOM_SETS / 2)
        queue_set(marker);
    end
    calm_from = operand_queue.size() - 2 - 150;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (operand_queue.size() != 0 || start || quot_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_cnt == 0 && quot_expected.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
